[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

[src/i2cm_pkg.sv]
// ---------------------------------------------------------------------------
// i2cm_pkg
// Types and constants of the I2C master byte engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cm_pkg;

   localparam logic [15:0] PHASE_DELAY_RESET = 16'd28;
   localparam logic [3:0]  BYTE_BITS         = 4'd8;

   typedef enum logic [3:0] {
      CMD_NONE  = 4'd0,
      CMD_START = 4'd1,
      CMD_STOP  = 4'd2,
      CMD_SEND  = 4'd3,
      CMD_WACK  = 4'd4,
      CMD_ACK   = 4'd5,
      CMD_NACK  = 4'd6,
      CMD_READ  = 4'd7,
      CMD_PROBE = 4'd8
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'd0,
      ST_SA   = 4'd1,
      ST_SB   = 4'd2,
      ST_SC   = 4'd3,
      ST_PA   = 4'd4,
      ST_TBIT = 4'd5,
      ST_THI  = 4'd6,
      ST_TLO  = 4'd7,
      ST_WA   = 4'd8,
      ST_WHI  = 4'd9,
      ST_WLO  = 4'd10,
      ST_KA   = 4'd11,
      ST_KHI  = 4'd12,
      ST_KLO  = 4'd13,
      ST_RHI  = 4'd14,
      ST_RLO  = 4'd15
   } step_type;

   typedef struct packed {
      logic [3:0] req_type;
      logic [7:0] tx_byte;
      logic       sda_in;
      logic       scl_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       nack_seen;
   } rsp_item_type;

endpackage

[src/i2c_master_byte_engine.sv]
// ---------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master sequencer: one request transfer is one tick of the bus engine.
// ---------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    req_item_type (command, byte, lines)
//   rsp_     out        rsp_valid/rsp_ready    rsp_item_type (drive, status, rx byte)
//   csr_     in         csr_valid/csr_ready    phase_delay, 16 bits
//
// One request transfer per cycle while req_ready is high; each yields exactly one
// response, registered in the head or skid entry after the step logic.
// A two-entry response buffer (head plus skid) keeps req_ready high while one
// response waits; req_ready drops only when both entries are held.
// Synchronous reset: engine idle, both lines released, phase_delay = 28.
// csr writes are always taken; they are meant for idle periods only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_engine
   import i2cm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_payload,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);

`include "assert_macros.svh"

   // engine state
   logic [15:0] phase_delay_ff;
   step_type    step_ff, step_in;
   logic [3:0]  cmd_ff, cmd_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic        ack_ff, ack_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        done_in;

   // response buffer
   rsp_item_type head_ff, head_in, skid_ff, skid_in;
   logic         head_vld_ff, head_vld_in, skid_vld_ff, skid_vld_in;

   logic         push, pop;
   logic         enter_en;
   step_type     enter_step;
   logic [3:0]   bit_next;
   logic [15:0]  delay_load;
   rsp_item_type rsp_new;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_vld_ff;
   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = head_vld_ff;
   assign rsp_payload = head_ff;

   // a zero delay behaves as one tick
   assign delay_load = (phase_delay_ff == 16'd0) ? 16'd1 : phase_delay_ff;
   assign bit_next   = bit_ff + 4'd1;

   // step logic: one tick of the sequencer
   always_comb begin
      step_in    = step_ff;
      cmd_in     = cmd_ff;
      cnt_in     = cnt_ff;
      bit_in     = bit_ff;
      tx_in      = tx_ff;
      rx_in      = rx_ff;
      ack_in     = ack_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      done_in    = 1'b0;
      enter_en   = 1'b0;
      enter_step = ST_IDLE;

      if (step_ff == ST_IDLE) begin
         if (req_payload.req_type >= CMD_START && req_payload.req_type <= CMD_PROBE) begin
            cmd_in = req_payload.req_type;
            case (req_payload.req_type)
               CMD_START: begin
                  enter_en = 1'b1; enter_step = ST_SA;
               end
               CMD_STOP: begin
                  enter_en = 1'b1; enter_step = ST_PA;
               end
               CMD_SEND: begin
                  tx_in = req_payload.tx_byte; bit_in = 4'd0;
                  enter_en = 1'b1; enter_step = ST_TBIT;
               end
               CMD_WACK: begin
                  enter_en = 1'b1; enter_step = ST_WA;
               end
               CMD_ACK, CMD_NACK: begin
                  enter_en = 1'b1; enter_step = ST_KA;
               end
               CMD_READ: begin
                  bit_in = 4'd0;
                  enter_en = 1'b1; enter_step = ST_RHI;
               end
               default: begin
                  // probe: bus must be idle high
                  if (req_payload.sda_in && req_payload.scl_in) begin
                     tx_in = req_payload.tx_byte;
                     enter_en = 1'b1; enter_step = ST_SA;
                  end else begin
                     ack_in = 1'b1; done_in = 1'b1;
                  end
               end
            endcase
         end
      end else if (cnt_ff > 16'd1) begin
         cnt_in = cnt_ff - 16'd1;
      end else begin
         case (step_ff)
            ST_SA: begin enter_en = 1'b1; enter_step = ST_SB; end
            ST_SB: begin enter_en = 1'b1; enter_step = ST_SC; end
            ST_SC: begin
               if (cmd_ff == CMD_PROBE) begin
                  bit_in = 4'd0; enter_en = 1'b1; enter_step = ST_TBIT;
               end else begin
                  step_in = ST_IDLE; done_in = 1'b1;
               end
            end
            ST_PA: begin
               sda_in = 1'b1; step_in = ST_IDLE; done_in = 1'b1;
            end
            ST_TBIT: begin enter_en = 1'b1; enter_step = ST_THI; end
            ST_THI:  begin enter_en = 1'b1; enter_step = ST_TLO; end
            ST_TLO: begin
               bit_in = bit_next;
               if (bit_next < BYTE_BITS) begin
                  enter_en = 1'b1; enter_step = ST_TBIT;
               end else begin
                  sda_in = 1'b1;
                  if (cmd_ff == CMD_PROBE) begin
                     enter_en = 1'b1; enter_step = ST_WA;
                  end else begin
                     step_in = ST_IDLE; done_in = 1'b1;
                  end
               end
            end
            ST_WA: begin enter_en = 1'b1; enter_step = ST_WHI; end
            ST_WHI: begin
               ack_in = req_payload.sda_in;
               enter_en = 1'b1; enter_step = ST_WLO;
            end
            ST_WLO: begin
               if (cmd_ff == CMD_PROBE) begin
                  enter_en = 1'b1; enter_step = ST_PA;
               end else begin
                  step_in = ST_IDLE; done_in = 1'b1;
               end
            end
            ST_KA:  begin enter_en = 1'b1; enter_step = ST_KHI; end
            ST_KHI: begin enter_en = 1'b1; enter_step = ST_KLO; end
            ST_KLO: begin
               sda_in = 1'b1; step_in = ST_IDLE; done_in = 1'b1;
            end
            ST_RHI: begin
               rx_in = {rx_ff[6:0], req_payload.sda_in};
               enter_en = 1'b1; enter_step = ST_RLO;
            end
            ST_RLO: begin
               bit_in = bit_next;
               if (bit_next < BYTE_BITS) begin
                  enter_en = 1'b1; enter_step = ST_RHI;
               end else begin
                  step_in = ST_IDLE; done_in = 1'b1;
               end
            end
            default: begin
               step_in = ST_IDLE; done_in = 1'b1;
            end
         endcase
      end

      // phase entry: load the delay and set the line drive
      if (enter_en) begin
         step_in = enter_step;
         cnt_in  = delay_load;
         case (enter_step)
            ST_SA: begin scl_in = 1'b1; sda_in = 1'b1; end
            ST_SB: sda_in = 1'b0;
            ST_SC: scl_in = 1'b0;
            ST_PA: begin sda_in = 1'b0; scl_in = 1'b1; end
            ST_TBIT: begin
               scl_in = 1'b0;
               sda_in = tx_in[7];
               tx_in  = {tx_in[6:0], 1'b0};
            end
            ST_WA: sda_in = 1'b1;
            ST_KA: sda_in = (cmd_in == CMD_ACK) ? 1'b0 : 1'b1;
            ST_THI, ST_WHI, ST_KHI, ST_RHI: scl_in = 1'b1;
            ST_TLO, ST_WLO, ST_KLO, ST_RLO: scl_in = 1'b0;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_new.scl_out   = scl_in;
      rsp_new.sda_out   = sda_in;
      rsp_new.busy_res  = (step_in != ST_IDLE);
      rsp_new.done_res  = done_in;
      rsp_new.rx_byte   = rx_in;
      rsp_new.nack_seen = ack_in;
   end

   // response buffer: head feeds the port, skid catches a transfer under stall
   always_comb begin
      head_in     = head_ff;
      skid_in     = skid_ff;
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            head_in     = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (head_vld_ff) begin
         if (push && pop) begin
            head_in = rsp_new;
         end else if (push) begin
            skid_in     = rsp_new;
            skid_vld_in = 1'b1;
         end else if (pop) begin
            head_vld_in = 1'b0;
         end
      end else if (push) begin
         head_in     = rsp_new;
         head_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_delay_ff <= PHASE_DELAY_RESET;
         step_ff        <= ST_IDLE;
         cmd_ff         <= CMD_NONE;
         cnt_ff         <= 16'd0;
         bit_ff         <= 4'd0;
         tx_ff          <= 8'd0;
         rx_ff          <= 8'd0;
         ack_ff         <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         head_vld_ff    <= 1'b0;
         skid_vld_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            phase_delay_ff <= csr_data;
         end
         if (push) begin
            step_ff <= step_in;
            cmd_ff  <= cmd_in;
            cnt_ff  <= cnt_in;
            bit_ff  <= bit_in;
            tx_ff   <= tx_in;
            rx_ff   <= rx_in;
            ack_ff  <= ack_in;
            scl_ff  <= scl_in;
            sda_ff  <= sda_in;
         end
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   // a running phase always has ticks left on its delay
   `ASSERT_IMPLY(a_busy_cnt, clock, reset, step_ff != ST_IDLE, cnt_ff != 16'd0)
   // bit counter never runs past one byte
   `ASSERT_CLK(a_bit_range, clock, reset, bit_ff <= BYTE_BITS)
   // a completing transfer reports the engine idle
   `ASSERT_IMPLY(a_done_idle, clock, reset, push && done_in, step_in == ST_IDLE)
   // skid entry is only held behind a valid head
   `ASSERT_IMPLY(a_skid_head, clock, reset, skid_vld_ff, head_vld_ff)

endmodule
